// ----- src/bhpq_pkg.sv -----
// Shared types and constants for the binary heap priority queue.
package bhpq_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_DATA_WIDTH = 32;

   // Operation codes carried on req_tuser
   localparam logic KIND_INSERT  = 1'b0;
   localparam logic KIND_EXTRACT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EX_ROOT,
      ST_EX_LAST,
      ST_UP_READ,
      ST_UP_CMP,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP,
      ST_DN_MOVE,
      ST_DONE
   } state_type;

endpackage

// ----- src/bhpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bhpq_cmp.sv -----
// Shared priority compare: true when a belongs above b in the heap.
module bhpq_cmp #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  min_mode,
   input  logic [DATA_WIDTH-1:0] a,
   input  logic [DATA_WIDTH-1:0] b,
   output logic                  better
);

   // strict order only: equal values never move
   always_comb begin
      if (min_mode) begin
         better = $signed(a) < $signed(b);
      end else begin
         better = $signed(a) > $signed(b);
      end
   end

endmodule

// ----- src/binary_heap_priority_queue.sv -----
// Binary heap priority queue: one RAM, one shared comparator, a small sequencer.
// Flow: an error goes straight to the result; an insert runs ST_UP_READ and ST_UP_CMP for
// each level it climbs; an extract reads the root, then the last element, and unless that
// emptied the heap runs ST_DN_LEFT, ST_DN_RIGHT and ST_DN_CMP or ST_DN_MOVE per level it
// sinks. A new item is taken only in ST_IDLE, after the result has entered the output
// register, which waits while it is full. Sync reset empties the heap, selects min mode.
module binary_heap_priority_queue #(
   parameter int CAPACITY   = bhpq_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = bhpq_pkg::DEF_DATA_WIDTH
) (
   input  logic clock,
   input  logic reset,

   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]       req_tdata,   // [0] up: value
   input  logic                                  req_tuser,   // kind

   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((DATA_WIDTH+$clog2(CAPACITY+1)+7)/8)*8-1:0] rsp_tdata,
                                                 // [0] up: root_out, occupancy
   output logic [1:0]                            rsp_tuser,   // empty_error, full_error

   // configuration
   input  logic                                  csr_we,
   input  logic                                  csr_wdata    // min_mode
);

   localparam int AW = $clog2(CAPACITY);        // heap index width
   localparam int CW = $clog2(CAPACITY + 1);    // element count width
   localparam int XW = AW + 2;                  // child index width, holds 2*pos+2

   bhpq_pkg::state_type state_ff, state_in;

   logic                  min_mode_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;          // element being sifted
   logic [DATA_WIDTH-1:0] best_val_ff, best_val_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;

   // result of the item in flight
   logic [DATA_WIDTH-1:0] res_root_ff, res_root_in;
   logic                  res_empty_ff, res_empty_in;
   logic                  res_full_ff, res_full_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_root_ff, rsp_root_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic [CW-1:0]         rsp_occ_ff, rsp_occ_in;

   // RAM and comparator hookup
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [DATA_WIDTH-1:0] ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic [DATA_WIDTH-1:0] cmp_a, cmp_b;
   logic                  cmp_better;

   logic [AW-1:0]         parent_idx;
   logic [XW-1:0]         left_idx, right_idx, count_x;

   assign parent_idx = AW'((pos_ff - 1'b1) >> 1);
   assign left_idx   = XW'({pos_ff, 1'b1});
   assign right_idx  = left_idx + 1'b1;
   assign count_x    = XW'(count_ff);

   bhpq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bhpq_cmp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_cmp (
      .min_mode (min_mode_ff),
      .a        (cmp_a),
      .b        (cmp_b),
      .better   (cmp_better)
   );

   // Sequencer: sift-up moves parents down into the hole, sift-down lifts the best
   // child into the hole; the sifted element itself is written once at the end.
   always_comb begin
      logic [DATA_WIDTH-1:0] mv_val;
      logic [AW-1:0]         mv_idx;
      logic                  do_move;

      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      best_val_in  = best_val_ff;
      best_idx_in  = best_idx_ff;
      res_root_in  = res_root_ff;
      res_empty_in = res_empty_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_root_in  = rsp_root_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_occ_in   = rsp_occ_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = val_ff;
      ram_raddr    = '0;
      cmp_a        = val_ff;
      cmp_b        = ram_rdata;
      req_tready   = 1'b0;
      mv_val       = best_val_ff;
      mv_idx       = best_idx_ff;
      do_move      = 1'b0;

      case (state_ff)
         bhpq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               res_root_in  = '0;
               res_empty_in = 1'b0;
               res_full_in  = 1'b0;
               if (req_tuser == bhpq_pkg::KIND_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     // drop the value
                     res_full_in = 1'b1;
                     state_in    = bhpq_pkg::ST_DONE;
                  end else begin
                     val_in   = req_tdata[DATA_WIDTH-1:0];
                     pos_in   = AW'(count_ff);
                     count_in = count_ff + 1'b1;
                     state_in = bhpq_pkg::ST_UP_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_root_in  = '1;
                     res_empty_in = 1'b1;
                     state_in     = bhpq_pkg::ST_DONE;
                  end else begin
                     ram_raddr = '0;
                     state_in  = bhpq_pkg::ST_EX_ROOT;
                  end
               end
            end
         end

         bhpq_pkg::ST_EX_ROOT: begin
            // root arrives; fetch the last element
            res_root_in = ram_rdata;
            ram_raddr   = AW'(count_ff - 1'b1);
            count_in    = count_ff - 1'b1;
            state_in    = bhpq_pkg::ST_EX_LAST;
         end

         bhpq_pkg::ST_EX_LAST: begin
            val_in = ram_rdata;
            pos_in = '0;
            if (count_ff == '0) begin
               state_in = bhpq_pkg::ST_DONE;
            end else begin
               state_in = bhpq_pkg::ST_DN_LEFT;
            end
         end

         bhpq_pkg::ST_UP_READ: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               state_in = bhpq_pkg::ST_DONE;
            end else begin
               ram_raddr = parent_idx;
               state_in  = bhpq_pkg::ST_UP_CMP;
            end
         end

         bhpq_pkg::ST_UP_CMP: begin
            cmp_a  = val_ff;
            cmp_b  = ram_rdata;
            ram_we = 1'b1;
            if (cmp_better) begin
               ram_wdata = ram_rdata;
               pos_in    = parent_idx;
               state_in  = bhpq_pkg::ST_UP_READ;
            end else begin
               state_in = bhpq_pkg::ST_DONE;
            end
         end

         bhpq_pkg::ST_DN_LEFT: begin
            if (left_idx >= count_x) begin
               ram_we   = 1'b1;
               state_in = bhpq_pkg::ST_DONE;
            end else begin
               ram_raddr = AW'(left_idx);
               state_in  = bhpq_pkg::ST_DN_RIGHT;
            end
         end

         bhpq_pkg::ST_DN_RIGHT: begin
            // left child against the sifted element
            cmp_a = ram_rdata;
            cmp_b = val_ff;
            if (cmp_better) begin
               best_val_in = ram_rdata;
               best_idx_in = AW'(left_idx);
            end else begin
               best_val_in = val_ff;
               best_idx_in = pos_ff;
            end
            if (right_idx < count_x) begin
               ram_raddr = AW'(right_idx);
               state_in  = bhpq_pkg::ST_DN_CMP;
            end else begin
               state_in = bhpq_pkg::ST_DN_MOVE;
            end
         end

         bhpq_pkg::ST_DN_CMP: begin
            // right child wins only when strictly better than the best so far
            cmp_a   = ram_rdata;
            cmp_b   = best_val_ff;
            do_move = 1'b1;
            if (cmp_better) begin
               mv_val = ram_rdata;
               mv_idx = AW'(right_idx);
            end
         end

         bhpq_pkg::ST_DN_MOVE: begin
            do_move = 1'b1;
         end

         bhpq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = res_root_ff;
               rsp_empty_in = res_empty_ff;
               rsp_full_in  = res_full_ff;
               rsp_occ_in   = count_ff;
               state_in     = bhpq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bhpq_pkg::ST_IDLE;
         end
      endcase

      if (do_move) begin
         ram_we = 1'b1;
         if (mv_idx == pos_ff) begin
            state_in = bhpq_pkg::ST_DONE;
         end else begin
            ram_wdata = mv_val;
            pos_in    = mv_idx;
            state_in  = bhpq_pkg::ST_DN_LEFT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bhpq_pkg::ST_IDLE;
         count_ff     <= '0;
         min_mode_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            min_mode_ff <= csr_wdata;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      best_val_ff  <= best_val_in;
      best_idx_ff  <= best_idx_in;
      res_root_ff  <= res_root_in;
      res_empty_ff <= res_empty_in;
      res_full_ff  <= res_full_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_full_ff, rsp_empty_ff};

   always_comb begin
      rsp_tdata                   = '0;
      rsp_tdata[DATA_WIDTH-1:0]   = rsp_root_ff;
      rsp_tdata[DATA_WIDTH +: CW] = rsp_occ_ff;
   end

endmodule

// ----- tb/binary_heap_priority_queue_test.sv -----
// Self-checking testbench for the binary heap priority queue: directed table, then random phases.
module binary_heap_priority_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = bhpq_pkg::DEF_CAPACITY;
   localparam int DATA_WIDTH  = bhpq_pkg::DEF_DATA_WIDTH;
   localparam int TOTAL_ITEMS = 1750;
   localparam int SCRIPT_LEN  = 22;

   // min_mode register values
   localparam logic MIN_ORDER = 1'b1;
   localparam logic MAX_ORDER = 1'b0;

   typedef struct packed {
      logic [31:0] root;
      logic        empty_err;
      logic        full_err;
      logic [6:0]  occ;
   } heap_result_type;

   // One directed step: either an item or a min_mode write (value[0] holds the mode).
   typedef struct packed {
      logic            is_csr;
      logic            kind;
      logic [31:0]     value;
      logic            typed;
      heap_result_type exp;
   } stim_row_type;

   localparam heap_result_type FROM_MODEL = '0;

   localparam stim_row_type SCRIPT [SCRIPT_LEN] = '{
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'hDEAD_BEEF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 7'd0}},
      '{1'b0, bhpq_pkg::KIND_INSERT,  32'h7FFF_FFFF, 1'b1, '{32'd0, 1'b0, 1'b0, 7'd1}},
      '{1'b0, bhpq_pkg::KIND_INSERT,  32'h8000_0000, 1'b1, '{32'd0, 1'b0, 1'b0, 7'd2}},
      '{1'b0, bhpq_pkg::KIND_INSERT,  32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, 1'b0, 7'd3}},
      '{1'b0, bhpq_pkg::KIND_INSERT,  32'h0000_0000, 1'b1, '{32'd0, 1'b0, 1'b0, 7'd4}},
      '{1'b0, bhpq_pkg::KIND_INSERT,  32'd7,         1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_INSERT,  32'd7,         1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'h5555_AAAA, 1'b1, '{32'h8000_0000, 1'b0, 1'b0, 7'd5}},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'hAAAA_5555, 1'b0, FROM_MODEL},
      // switch to max order with four elements still held
      '{1'b1, bhpq_pkg::KIND_INSERT,  32'(MAX_ORDER), 1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_INSERT,  32'd3,         1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'h0,         1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'h0,         1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'h0,         1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'h0,         1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'hFFFF_FFFF, 1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'h0,         1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 7'd0}},
      '{1'b0, bhpq_pkg::KIND_INSERT,  32'h8000_0000, 1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_INSERT,  32'h7FFF_FFFF, 1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'h0,         1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0, 7'd1}},
      '{1'b1, bhpq_pkg::KIND_INSERT,  32'(MIN_ORDER), 1'b0, FROM_MODEL},
      '{1'b0, bhpq_pkg::KIND_EXTRACT, 32'h0,         1'b1, '{32'h8000_0000, 1'b0, 1'b0, 7'd0}}
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;      // [31:0] value
   logic        req_tuser  = bhpq_pkg::KIND_INSERT; // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [31:0] root_out, [38:32] occupancy
   logic [1:0]  rsp_tuser;            // [0] empty_error, [1] full_error
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = MIN_ORDER; // min_mode

   binary_heap_priority_queue #(
      .CAPACITY  (CAPACITY),
      .DATA_WIDTH(DATA_WIDTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // heap mirror
   logic signed [31:0] heap_mirror [CAPACITY];
   int unsigned        heap_fill;
   logic               min_first;

   heap_result_type reply_queue [$];
   heap_result_type typed_reply;
   logic            use_typed    = 1'b0;
   int              items_sent   = 0;
   int              error_count  = 0;
   int              req_idle_pct = 22;
   int              rsp_idle_pct = 22;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("binary_heap_priority_queue_test: errors");
      $finish;
   end

   function automatic logic outranks(input logic signed [31:0] a, input logic signed [31:0] b);
      return min_first ? (a < b) : (a > b);
   endfunction

   // Apply one operation to the mirror and return the reply it owes.
   function automatic heap_result_type heap_apply(input logic kind, input logic [31:0] v);
      heap_result_type    r;
      int unsigned        pos;
      int unsigned        up;
      int unsigned        pick;
      logic signed [31:0] t;
      r = '0;
      if (kind == bhpq_pkg::KIND_INSERT) begin
         if (heap_fill >= CAPACITY) begin
            r.full_err = 1'b1;
         end else begin
            pos = heap_fill;
            heap_mirror[pos] = v;
            heap_fill++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!outranks(heap_mirror[pos], heap_mirror[up])) break;
               t = heap_mirror[pos];
               heap_mirror[pos] = heap_mirror[up];
               heap_mirror[up] = t;
               pos = up;
            end
         end
      end else if (heap_fill == 0) begin
         r.root      = '1;
         r.empty_err = 1'b1;
      end else begin
         r.root = heap_mirror[0];
         heap_fill--;
         heap_mirror[0] = heap_mirror[heap_fill];
         pos = 0;
         while (1'b1) begin
            pick = pos;
            // left child first; right wins only when strictly better
            if (2 * pos + 1 < heap_fill && outranks(heap_mirror[2 * pos + 1], heap_mirror[pick]))
               pick = 2 * pos + 1;
            if (2 * pos + 2 < heap_fill && outranks(heap_mirror[2 * pos + 2], heap_mirror[pick]))
               pick = 2 * pos + 2;
            if (pick == pos) break;
            t = heap_mirror[pos];
            heap_mirror[pos] = heap_mirror[pick];
            heap_mirror[pick] = t;
            pos = pick;
         end
      end
      r.occ = 7'(heap_fill);
      return r;
   endfunction

   // Check replies first, then predict the item taken at the same edge.
   always @(posedge clock) begin
      heap_result_type got;
      heap_result_type want;
      heap_result_type pred;
      if (reset) begin
         heap_fill = 0;
         min_first = MIN_ORDER;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tuser[0], rsp_tuser[1], rsp_tdata[38:32]};
            if (reply_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected reply root %0d empty %b full %b occ %0d", $time,
                        $signed(got.root), got.empty_err, got.full_err, got.occ);
            end else begin
               want = reply_queue.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: expected root %0d empty %b full %b occ %0d,", $time,
                           $signed(want.root), want.empty_err, want.full_err, want.occ);
                  $display("%0t: got root %0d empty %b full %b occ %0d", $time,
                           $signed(got.root), got.empty_err, got.full_err, got.occ);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pred = heap_apply(req_tuser, req_tdata);
            if (use_typed) pred = typed_reply;
            reply_queue = {reply_queue, pred};
         end
         if (csr_we) min_first = csr_wdata;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= (rsp_idle_pct == 0) || ($urandom_range(99) >= rsp_idle_pct);
   end

   // Present one item, holding it until taken; valid stays high for a back-to-back item.
   task automatic push_item(input logic kind, input logic [31:0] v);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (reply_queue.size() != 0) @(negedge clock);
   endtask

   // Write min_mode only with the queue idle and every reply in.
   task automatic write_order(input logic mode);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int          phase_no;
      int          len;
      int          insert_pct;
      int          sel;
      logic        kind;
      logic [31:0] v;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         if (SCRIPT[i].is_csr) begin
            write_order(SCRIPT[i].value[0]);
         end else begin
            use_typed   = SCRIPT[i].typed;
            typed_reply = SCRIPT[i].exp;
            push_item(SCRIPT[i].kind, SCRIPT[i].value);
         end
      end
      use_typed = 1'b0;

      // Fill past capacity, drain past empty, and churn in between.
      phase_no = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (phase_no % 3 == 2) write_order(1'($urandom_range(1)));
         if (phase_no == 5) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 22;
            rsp_idle_pct = 22;
         end
         case (phase_no % 4)
            0: begin
               insert_pct = 88;
               len = 90;
            end
            1: begin
               insert_pct = 12;
               len = 90;
            end
            2: begin
               insert_pct = 50;
               len = 60 + $urandom_range(60);
            end
            default: begin
               insert_pct = 65;
               len = 60 + $urandom_range(60);
            end
         endcase
         if (phase_no == 5) len = 250;
         for (int n = 0; n < len && items_sent < TOTAL_ITEMS; n++) begin
            kind = ($urandom_range(99) < insert_pct) ? bhpq_pkg::KIND_INSERT
                                                     : bhpq_pkg::KIND_EXTRACT;
            sel = $urandom_range(9);
            if (sel == 0) begin
               case ($urandom_range(3))
                  0: v = 32'h8000_0000;
                  1: v = 32'h7FFF_FFFF;
                  2: v = 32'h0000_0000;
                  default: v = 32'hFFFF_FFFF;
               endcase
            end else if (sel <= 3) begin
               // narrow range to force ties
               v = 32'($urandom_range(8)) - 32'd4;
            end else begin
               v = $urandom;
            end
            push_item(kind, v);
         end
         phase_no++;
      end

      wait_drained();
      repeat (48) @(negedge clock);
      if (error_count == 0) begin
         $display("binary_heap_priority_queue_test: clean");
      end else begin
         $display("binary_heap_priority_queue_test: errors");
      end
      $finish;
   end

endmodule
